FILE: hdl/pqr_pkg.sv
// ============================================================================
// pqr_pkg
// Shared sizes, operation codes and status codes of the process id queue.
// ============================================================================
package pqr_pkg;

	localparam int QUEUE_DEPTH = 16;                      // 2 .. 31 entries
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);     // slot address
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1); // 0 .. QUEUE_DEPTH

	localparam int ID_W    = 8;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 5;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam op_t OP_ENQUEUE = 2'd0;
	localparam op_t OP_DEQUEUE = 2'd1;
	localparam op_t OP_REMOVE  = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	// circular slot pointer increment
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

FILE: hdl/process_queue_remove_by_id.sv
// ============================================================================
// process_queue_remove_by_id
// FIFO of 8-bit process ids with enqueue, dequeue and remove-by-id.
// ============================================================================
// Ids sit in a circular slot memory of pqr_pkg::QUEUE_DEPTH entries, head
// pointer plus count. One transaction is taken at a time; s_tready is high
// only while the sequencer is idle. Every request yields exactly one result
// transaction. Enqueue, error cases and unused codes go from the execute
// state straight to the result state; dequeue first takes one memory
// read. Remove-by-id reads the memory through its single registered read
// port, one slot per cycle, comparing against the wanted id: a match at
// position p of n entries scans p + 1 slots, then a close-up pass moves each
// of the n - p - 1 later entries one slot toward the head (one read and one
// write per cycle). A miss scans all n slots. While an earlier result waits
// untaken in the output register, the sequencer holds in its final state
// until m_tready. Slots have no reset; only slots below the count are ever
// read.
module process_queue_remove_by_id (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] item_id
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] removed_id, [12:8] entry_total,
	                               // [13] is_empty, [15:14] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_DEQ_TAKE = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_SHIFT    = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	localparam int SUM_W = pqr_pkg::CNT_W + 1;

	logic [2:0]        state_q;
	pqr_pkg::op_t      op_q;
	pqr_pkg::id_t      id_q;
	pqr_pkg::ptr_t     head_q;
	pqr_pkg::cnt_t     count_q;
	pqr_pkg::ptr_t     addr_q;     // scan position / close-up destination
	pqr_pkg::ptr_t     src_q;      // close-up source
	pqr_pkg::cnt_t     idx_q;      // queue position of addr_q
	pqr_pkg::status_t  res_status_q;
	pqr_pkg::id_t      res_id_q;

	logic              out_valid_q;
	logic [15:0]       out_data_q;
	pqr_pkg::status_t  out_user_q;

	// slot memory
	pqr_pkg::id_t      mem [pqr_pkg::QUEUE_DEPTH];
	pqr_pkg::id_t      rd_data_q;
	logic              rd_en;
	pqr_pkg::ptr_t     rd_addr;
	logic              wr_en;
	pqr_pkg::ptr_t     wr_addr;
	pqr_pkg::id_t      wr_data;

	// derived values
	logic              full;
	logic              empty;
	logic [SUM_W-1:0]  tail_sum;
	pqr_pkg::ptr_t     tail_addr;
	logic [SUM_W-1:0]  idx_p1;
	logic [SUM_W-1:0]  idx_p2;
	logic [SUM_W-1:0]  count_ext;
	logic              out_free;
	logic [31:0]       total_wide;

	assign full      = (count_q == pqr_pkg::CNT_W'(pqr_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	// head + count stays below twice the depth while not full
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_addr = (tail_sum >= SUM_W'(pqr_pkg::QUEUE_DEPTH))
		? pqr_pkg::PTR_W'(tail_sum - SUM_W'(pqr_pkg::QUEUE_DEPTH))
		: pqr_pkg::PTR_W'(tail_sum);
	assign idx_p1    = SUM_W'(idx_q) + SUM_W'(1);
	assign idx_p2    = SUM_W'(idx_q) + SUM_W'(2);
	assign count_ext = SUM_W'(count_q);
	assign out_free  = !out_valid_q || m_tready;
	assign total_wide = 32'(count_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = tail_addr;
		wr_data = id_q;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == pqr_pkg::OP_ENQUEUE && !full) begin
					wr_en = 1'b1;
				end
				if ((op_q == pqr_pkg::OP_DEQUEUE || op_q == pqr_pkg::OP_REMOVE) && !empty) begin
					rd_en = 1'b1;
				end
			end
			S_SCAN: begin
				if (rd_data_q == id_q) begin
					rd_en   = (idx_p1 < count_ext);
					rd_addr = pqr_pkg::ptr_next(addr_q);
				end else if (idx_p1 != count_ext) begin
					rd_en   = 1'b1;
					rd_addr = pqr_pkg::ptr_next(addr_q);
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = rd_data_q;
				rd_en   = (idx_p2 < count_ext);
				rd_addr = pqr_pkg::ptr_next(src_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= s_tuser;
			id_q <= s_tdata;
		end
		unique case (state_q)
			S_EXEC: begin
				res_id_q <= '0;
				addr_q   <= head_q;
				idx_q    <= '0;
				unique case (op_q)
					pqr_pkg::OP_ENQUEUE: begin
						res_status_q <= full ? pqr_pkg::ST_FULL : pqr_pkg::ST_OK;
					end
					pqr_pkg::OP_DEQUEUE: begin
						res_status_q <= empty ? pqr_pkg::ST_EMPTY : pqr_pkg::ST_OK;
					end
					pqr_pkg::OP_REMOVE: begin
						res_status_q <= empty ? pqr_pkg::ST_EMPTY : pqr_pkg::ST_OK;
					end
					default: begin
						res_status_q <= pqr_pkg::ST_OK;
					end
				endcase
			end
			S_DEQ_TAKE: begin
				res_id_q <= rd_data_q;
			end
			S_SCAN: begin
				if (rd_data_q == id_q) begin
					res_id_q <= rd_data_q;
					src_q    <= pqr_pkg::ptr_next(addr_q);
				end else if (idx_p1 == count_ext) begin
					res_status_q <= pqr_pkg::ST_NOT_FOUND;
				end else begin
					addr_q <= pqr_pkg::ptr_next(addr_q);
					idx_q  <= pqr_pkg::CNT_W'(idx_p1);
				end
			end
			S_SHIFT: begin
				addr_q <= src_q;
				src_q  <= pqr_pkg::ptr_next(src_q);
				idx_q  <= pqr_pkg::CNT_W'(idx_p1);
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_user_q <= res_status_q;
			out_data_q <= {2'b00, empty, total_wide[pqr_pkg::TOTAL_W-1:0], res_id_q};
		end
	end

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load from the final state, clear once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (op_q)
						pqr_pkg::OP_ENQUEUE: begin
							state_q <= S_DONE;
							if (!full) count_q <= count_q + pqr_pkg::CNT_W'(1);
						end
						pqr_pkg::OP_DEQUEUE: begin
							state_q <= empty ? S_DONE : S_DEQ_TAKE;
						end
						pqr_pkg::OP_REMOVE: begin
							state_q <= empty ? S_DONE : S_SCAN;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_DEQ_TAKE: begin
					head_q  <= pqr_pkg::ptr_next(head_q);
					count_q <= count_q - pqr_pkg::CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (rd_data_q == id_q) begin
						if (idx_p1 < count_ext) begin
							state_q <= S_SHIFT;
						end else begin
							count_q <= count_q - pqr_pkg::CNT_W'(1);
							state_q <= S_DONE;
						end
					end else if (idx_p1 == count_ext) begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (!(idx_p2 < count_ext)) begin
						count_q <= count_q - pqr_pkg::CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pqr_pkg::CNT_W'(pqr_pkg::QUEUE_DEPTH))
		else $error("entry count above depth");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> (idx_q < count_q))
		else $error("scan or close-up position past tail");

	a_err_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != pqr_pkg::ST_OK) |-> (m_tdata[7:0] == '0))
		else $error("error result carries a removed id");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == pqr_pkg::ST_EMPTY) |-> m_tdata[13])
		else $error("empty status without empty flag");

	a_take_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEQ_TAKE) |=> (count_q == $past(count_q) - pqr_pkg::CNT_W'(1)))
		else $error("dequeue did not shrink the queue");

endmodule

FILE: tb/process_queue_remove_by_id_tb.sv
// ============================================================================
// process_queue_remove_by_id_tb
// Self-checking bench for the process id queue with remove-by-id.
// ============================================================================
// A table of directed requests runs first. It covers the empty and full
// queue, a match at the head, a match in the middle and at the tail,
// duplicates, a miss and the unused operation code. Randomized phases follow.
// Some phases fill the queue, some drain it, some mix both, and some use a
// narrow id pool to force duplicates. Each accepted request runs through a
// queue predictor. Each result transaction is compared field by field with
// the oldest prediction. Both stream sides get random gaps. The receiver
// holds off once for a long stretch, and the sender pauses once until all
// results are back.
module process_queue_remove_by_id_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam pqr_pkg::op_t OP_UNUSED = 2'd3;  // no operation assigned to this code
	localparam int RANDOM_ITEMS = 1350;
	localparam int PAUSE_AT     = 900;   // sender waits for a full drain here
	localparam int LONG_HOLD_AT = 600;   // receiver holds off after this many results
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int IDLE_LIMIT   = 4000;

	// one result transaction, in field terms
	typedef struct packed {
		pqr_pkg::status_t             status;
		pqr_pkg::id_t                 removed;
		logic [pqr_pkg::TOTAL_W-1:0]  total;
		logic                         empty;
	} outcome_t;

	typedef struct {
		pqr_pkg::op_t  op;
		pqr_pkg::id_t  id;
		int            rep;      // repeat count, id advances by one per repeat
		bit            typed;    // known holds the result read off by hand
		outcome_t      known;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] item_id
	logic [1:0]  s_tuser;   // [1:0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] removed_id, [12:8] entry_total, [13] is_empty
	logic [1:0]  m_tuser;   // [1:0] status

	plan_row_t     plan[$];
	outcome_t      pending_results[$];   // predictions waiting for their transaction
	pqr_pkg::id_t  held_ids[$];          // predicted queue contents, head first
	int        mismatch_total = 0;
	int        results_taken  = 0;
	int        sender_steady  = 0;   // remaining requests sent back to back

	process_queue_remove_by_id uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request to the predicted queue and return its result.
	function automatic outcome_t queue_predict(input pqr_pkg::op_t op, input pqr_pkg::id_t id);
		outcome_t r;
		int pos;
		r = '0;
		r.status = pqr_pkg::ST_OK;
		pos = -1;
		case (op)
			pqr_pkg::OP_ENQUEUE: begin
				if (held_ids.size() >= pqr_pkg::QUEUE_DEPTH) begin
					r.status = pqr_pkg::ST_FULL;
				end else begin
					held_ids.push_back(id);
				end
			end
			pqr_pkg::OP_DEQUEUE: begin
				if (held_ids.size() == 0) begin
					r.status = pqr_pkg::ST_EMPTY;
				end else begin
					r.removed = held_ids.pop_front();
				end
			end
			pqr_pkg::OP_REMOVE: begin
				if (held_ids.size() == 0) begin
					r.status = pqr_pkg::ST_EMPTY;
				end else begin
					// first match from the head wins, the rest keep order
					for (int i = 0; i < held_ids.size(); i++) begin
						if (pos < 0 && held_ids[i] == id) begin
							pos = i;
						end
					end
					if (pos < 0) begin
						r.status = pqr_pkg::ST_NOT_FOUND;
					end else begin
						r.removed = held_ids[pos];
						held_ids.delete(pos);
					end
				end
			end
			default: ;  // unused code leaves the queue alone
		endcase
		r.total = pqr_pkg::TOTAL_W'(held_ids.size());
		r.empty = (held_ids.size() == 0);
		return r;
	endfunction

	task automatic add_row(input pqr_pkg::op_t op, input pqr_pkg::id_t id, input int rep = 1,
			input bit typed = 1'b0, input pqr_pkg::status_t st = pqr_pkg::ST_OK,
			input pqr_pkg::id_t rem = '0, input int tot = 0, input bit emp = 1'b0);
		plan_row_t row;
		row.op    = op;
		row.id    = id;
		row.rep   = rep;
		row.typed = typed;
		row.known = '{status: st, removed: rem, total: pqr_pkg::TOTAL_W'(tot), empty: emp};
		plan.push_back(row);
	endtask

	// Mostly short gaps, a few long ones, and some back-to-back stretches.
	function automatic int pick_gap();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap = 0;
		if (sender_steady > 0) begin
			sender_steady--;
		end else if (roll < 4) begin
			sender_steady = $urandom_range(20, 80);
		end else if (roll < 50) begin
			gap = 0;
		end else if (roll < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		return gap;
	endfunction

	// Offer one request. Wait for the transaction, then queue the result
	// that is due.
	task automatic offer_request(input pqr_pkg::op_t op, input pqr_pkg::id_t id,
			input bit typed, input outcome_t known);
		int gap;
		outcome_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= id;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = queue_predict(op, id);
		pending_results.push_back(typed ? known : predicted);
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Stimulus: reset, directed table, random phases, drain.
	initial begin
		int phase_kind;
		int phase_left;
		int roll;
		int enq_lim;
		int deq_lim;
		int rem_lim;
		pqr_pkg::id_t narrow_base;
		pqr_pkg::op_t op;
		pqr_pkg::id_t id;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = pqr_pkg::OP_ENQUEUE;
		m_tready = 1'b0;
		phase_left = 0;
		phase_kind = 0;
		narrow_base = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// empty queue after reset
		add_row(pqr_pkg::OP_DEQUEUE, 8'h00, 1, 1'b1, pqr_pkg::ST_EMPTY, 8'h00, 0, 1'b1);
		add_row(pqr_pkg::OP_REMOVE,  8'hFF, 1, 1'b1, pqr_pkg::ST_EMPTY, 8'h00, 0, 1'b1);
		add_row(OP_UNUSED,           8'hAA, 1, 1'b1, pqr_pkg::ST_OK,    8'h00, 0, 1'b1);
		// single entry removed by id: match at the head
		add_row(pqr_pkg::OP_ENQUEUE, 8'h00, 1, 1'b1, pqr_pkg::ST_OK,    8'h00, 1, 1'b0);
		add_row(pqr_pkg::OP_REMOVE,  8'h00, 1, 1'b1, pqr_pkg::ST_OK,    8'h00, 0, 1'b1);
		// duplicates: FF 55 FF AA
		add_row(pqr_pkg::OP_ENQUEUE, 8'hFF, 1, 1'b1, pqr_pkg::ST_OK,    8'h00, 1, 1'b0);
		add_row(pqr_pkg::OP_ENQUEUE, 8'h55);
		add_row(pqr_pkg::OP_ENQUEUE, 8'hFF);
		add_row(pqr_pkg::OP_ENQUEUE, 8'hAA);
		add_row(pqr_pkg::OP_REMOVE,  8'h12, 1, 1'b1, pqr_pkg::ST_NOT_FOUND, 8'h00, 4, 1'b0);
		add_row(pqr_pkg::OP_REMOVE,  8'hFF);        // head copy goes, later copy stays
		add_row(pqr_pkg::OP_REMOVE,  8'hAA);        // tail
		add_row(pqr_pkg::OP_DEQUEUE, 8'h00, 2);
		// fill to the brim with ids 01..10
		add_row(pqr_pkg::OP_ENQUEUE, 8'h01, pqr_pkg::QUEUE_DEPTH);
		add_row(pqr_pkg::OP_ENQUEUE, 8'h80, 1, 1'b1, pqr_pkg::ST_FULL, 8'h00,
			pqr_pkg::QUEUE_DEPTH, 1'b0);
		add_row(OP_UNUSED,           8'h7F, 1, 1'b1, pqr_pkg::ST_OK,   8'h00,
			pqr_pkg::QUEUE_DEPTH, 1'b0);
		add_row(pqr_pkg::OP_REMOVE,  8'h08);        // middle
		add_row(pqr_pkg::OP_REMOVE,  8'h10);        // tail, one below full
		add_row(pqr_pkg::OP_ENQUEUE, 8'hFE);
		add_row(pqr_pkg::OP_ENQUEUE, 8'h01);        // duplicate of the head
		add_row(pqr_pkg::OP_REMOVE,  8'h01);
		add_row(pqr_pkg::OP_REMOVE,  8'hEE);        // miss on a long queue
		add_row(pqr_pkg::OP_DEQUEUE, 8'h00, pqr_pkg::QUEUE_DEPTH - 1);
		add_row(pqr_pkg::OP_DEQUEUE, 8'hFF, 1, 1'b1, pqr_pkg::ST_EMPTY, 8'h00, 0, 1'b1);

		foreach (plan[r]) begin
			for (int k = 0; k < plan[r].rep; k++) begin
				offer_request(plan[r].op, plan[r].id + pqr_pkg::id_t'(k), plan[r].typed,
					plan[r].known);
			end
		end
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_kind  = $urandom_range(0, 3);
				phase_left  = $urandom_range(10, 60);
				narrow_base = pqr_pkg::id_t'($urandom_range(0, 255));
			end
			phase_left--;
			case (phase_kind)
				0:       begin enq_lim = 70; deq_lim = 80; rem_lim = 96; end  // fill
				1:       begin enq_lim = 15; deq_lim = 50; rem_lim = 96; end  // drain
				2:       begin enq_lim = 40; deq_lim = 65; rem_lim = 96; end  // mixed
				default: begin enq_lim = 55; deq_lim = 65; rem_lim = 96; end  // dups
			endcase
			roll = $urandom_range(0, 99);
			if (roll < enq_lim) begin
				op = pqr_pkg::OP_ENQUEUE;
			end else if (roll < deq_lim) begin
				op = pqr_pkg::OP_DEQUEUE;
			end else if (roll < rem_lim) begin
				op = pqr_pkg::OP_REMOVE;
			end else begin
				op = OP_UNUSED;
			end
			if (phase_kind == 3) begin
				id = narrow_base + pqr_pkg::id_t'($urandom_range(0, 3));
			end else begin
				id = pqr_pkg::id_t'($urandom_range(0, 255));
			end
			// most removes aim at an entry that is present, anywhere in the queue
			if (op == pqr_pkg::OP_REMOVE && held_ids.size() > 0 && $urandom_range(0, 99) < 80)
			begin
				id = held_ids[$urandom_range(0, held_ids.size() - 1)];
			end
			if (n == PAUSE_AT) begin
				drain_results();
			end
			offer_request(op, id, 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && pending_results.size() == 0) begin
			$display("process_queue_remove_by_id_tb: clean");
		end else begin
			$display("process_queue_remove_by_id_tb: errors");
		end
		$finish;
	end

	// Result side: random stalls and one long hold-off. The long hold-off
	// backs up the block, so s_tready stays low while the sender keeps offering.
	initial begin
		int hold;
		int steady;
		int roll;
		bit long_done;
		hold = 0;
		steady = 0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_done && results_taken >= LONG_HOLD_AT) begin
				hold = LONG_HOLD;
				long_done = 1'b1;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (steady > 0) begin
				m_tready <= 1'b1;
				steady--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					m_tready <= 1'b1;
					steady = $urandom_range(40, 150);
				end else if (roll < 18) begin
					m_tready <= 1'b0;
					hold = (roll < 16) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_taken++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, status %0d data %h",
					$time, m_tuser, m_tdata);
				mismatch_total++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$display("%0t ns: status expected %0d got %0d",
						$time, want.status, m_tuser);
					mismatch_total++;
				end
				if (m_tdata[7:0] !== want.removed) begin
					$display("%0t ns: removed_id expected %h got %h",
						$time, want.removed, m_tdata[7:0]);
					mismatch_total++;
				end
				if (m_tdata[12:8] !== want.total) begin
					$display("%0t ns: entry_total expected %0d got %0d",
						$time, want.total, m_tdata[12:8]);
					mismatch_total++;
				end
				if (m_tdata[13] !== want.empty) begin
					$display("%0t ns: is_empty expected %0d got %0d",
						$time, want.empty, m_tdata[13]);
					mismatch_total++;
				end
				if (m_tdata[15:14] !== 2'b00) begin
					$display("%0t ns: pad bits expected 0 got %b", $time, m_tdata[15:14]);
					mismatch_total++;
				end
			end
		end
	end

	// Watchdog: too many cycles without a transaction on either side.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("process_queue_remove_by_id_tb: errors");
		$finish;
	end

endmodule

FILE: process_queue_remove_by_id.f
hdl/pqr_pkg.sv
hdl/process_queue_remove_by_id.sv
tb/process_queue_remove_by_id_tb.sv
